FILE: src/ufsz_pkg.sv
package ufsz_pkg;

  localparam int unsigned NUM_ELEMENTS_DEF = 65536;
  localparam int unsigned IN_W             = 16;
  localparam int unsigned SIZE_W           = 17;
  localparam int unsigned EPOCH_W          = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_RED,
    OP_FIND_START,
    OP_FIND,
    OP_CMP_START,
    OP_CMP,
    OP_EXT_RA,
    OP_EXT_RB,
    OP_SUM
  } ufsz_op_e;

  typedef struct packed {
    ufsz_op_e op;
    logic     sel;
  } ufsz_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic red_last;
    logic find_done;
    logic cmp_done;
    logic wrap_req;
    logic out_busy;
  } ufsz_sts_t;

endpackage

FILE: src/union_find_with_set_size_core.sv
// Disjoint-set store with set sizes over NUM_ELEMENTS elements. Each input transaction names
// two elements (indices are reduced modulo NUM_ELEMENTS) and an optional new_group flag that
// first returns every element to a singleton set; the block finds both roots, compresses both
// paths, links the first root under the second when they differ and returns the size of the
// merged set as one output transaction. Items are handled one at a time, and the parent-link
// memory, read once per cycle, sets the pace: an item's time grows with da and db, the path
// lengths from each element to its root, and index reduction adds time when NUM_ELEMENTS
// is below 65536. A finished result waits in an output register while the next item is
// accepted. After reset, and on every 16th transaction that sets new_group, a clearing pass
// rewrites both memories before work continues; other new_group requests cost nothing extra.
module union_find_with_set_size_core import ufsz_pkg::*; #(
  parameter int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IN_W-1:0]   elem_a_i,
  input  logic [IN_W-1:0]   elem_b_i,
  input  logic              new_group_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SIZE_W-1:0] set_size_o
);

  ufsz_cmd_t cmd;
  ufsz_sts_t sts;

  ufsz_ctrl #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ufsz_dp #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .elem_a_i   (elem_a_i),
    .elem_b_i   (elem_b_i),
    .new_group_i(new_group_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .set_size_o (set_size_o)
  );

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("A second transaction was accepted while one is in progress.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> cmd.op != OP_SUM)
    else $error("A pending result was overwritten.");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> set_size_o != '0)
    else $error("A set size of zero was reported.");
`endif

endmodule

FILE: src/ufsz_ctrl.sv
module ufsz_ctrl import ufsz_pkg::*; #(
  parameter int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ufsz_sts_t sts_i,
  output ufsz_cmd_t cmd_o
);

  localparam bit NEED_RED = (NUM_ELEMENTS < (1 << IN_W));

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_RED  = 4'd3;
  localparam logic [3:0] S_FA0  = 4'd4;
  localparam logic [3:0] S_FA   = 4'd5;
  localparam logic [3:0] S_CA0  = 4'd6;
  localparam logic [3:0] S_CA   = 4'd7;
  localparam logic [3:0] S_FB0  = 4'd8;
  localparam logic [3:0] S_FB   = 4'd9;
  localparam logic [3:0] S_CB0  = 4'd10;
  localparam logic [3:0] S_CB   = 4'd11;
  localparam logic [3:0] S_XA   = 4'd12;
  localparam logic [3:0] S_XB   = 4'd13;
  localparam logic [3:0] S_SUM  = 4'd14;

  localparam logic [3:0] S_WALK = NEED_RED ? S_RED : S_FA0;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.op = OP_CLR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = sts_i.wrap_req ? S_CLR : S_WALK;
        end
      end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (sts_i.clr_last) begin
          state_d = S_WALK;
        end
      end
      S_RED: begin
        cmd_o.op = OP_RED;
        if (sts_i.red_last) begin
          state_d = S_FA0;
        end
      end
      S_FA0: begin
        cmd_o.op = OP_FIND_START;
        state_d  = S_FA;
      end
      S_FA: begin
        cmd_o.op = OP_FIND;
        if (sts_i.find_done) begin
          state_d = S_CA0;
        end
      end
      S_CA0: begin
        cmd_o.op = OP_CMP_START;
        state_d  = S_CA;
      end
      S_CA: begin
        cmd_o.op = OP_CMP;
        if (sts_i.cmp_done) begin
          state_d = S_FB0;
        end
      end
      S_FB0: begin
        cmd_o.op  = OP_FIND_START;
        cmd_o.sel = 1'b1;
        state_d   = S_FB;
      end
      S_FB: begin
        cmd_o.op  = OP_FIND;
        cmd_o.sel = 1'b1;
        if (sts_i.find_done) begin
          state_d = S_CB0;
        end
      end
      S_CB0: begin
        cmd_o.op  = OP_CMP_START;
        cmd_o.sel = 1'b1;
        state_d   = S_CB;
      end
      S_CB: begin
        cmd_o.op  = OP_CMP;
        cmd_o.sel = 1'b1;
        if (sts_i.cmp_done) begin
          state_d = S_XA;
        end
      end
      S_XA: begin
        cmd_o.op = OP_EXT_RA;
        state_d  = S_XB;
      end
      S_XB: begin
        cmd_o.op = OP_EXT_RB;
        state_d  = S_SUM;
      end
      S_SUM: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_SUM;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/ufsz_dp.sv
module ufsz_dp import ufsz_pkg::*; #(
  parameter int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufsz_cmd_t         cmd_i,
  output ufsz_sts_t         sts_o,
  input  logic [IN_W-1:0]   elem_a_i,
  input  logic [IN_W-1:0]   elem_b_i,
  input  logic              new_group_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [SIZE_W-1:0] set_size_o
);

  localparam int unsigned IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int unsigned P_W   = EPOCH_W + IDX_W;
  localparam int unsigned X_W   = EPOCH_W + SIZE_W;
  localparam int unsigned RED_STEPS = 4;
  localparam logic [2*IN_W-1:0] MOD_N    = (2*IN_W)'(NUM_ELEMENTS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);

  logic [P_W-1:0] p_mem [NUM_ELEMENTS];
  logic [X_W-1:0] x_mem [NUM_ELEMENTS];

  logic             p_we;
  logic [IDX_W-1:0] p_waddr;
  logic [P_W-1:0]   p_wdata;
  logic [IDX_W-1:0] p_raddr;
  logic [P_W-1:0]   p_rdata_q;
  logic [IDX_W-1:0] p_raddr_q;

  logic             x_we;
  logic [IDX_W-1:0] x_waddr;
  logic [X_W-1:0]   x_wdata;
  logic [IDX_W-1:0] x_raddr;
  logic [X_W-1:0]   x_rdata_q;

  logic [EPOCH_W-1:0] epoch_q;
  logic [EPOCH_W-1:0] epoch_d;
  logic [IDX_W-1:0]   clr_cnt_q;
  logic [IDX_W-1:0]   clr_cnt_d;
  logic [1:0]         red_cnt_q;
  logic [1:0]         red_cnt_d;
  logic               out_valid_q;
  logic               out_valid_d;

  logic [IN_W-1:0]   red_a_q;
  logic [IN_W-1:0]   red_b_q;
  logic [IN_W-1:0]   red_a_next;
  logic [IN_W-1:0]   red_b_next;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  cur_d;
  logic [IDX_W-1:0]  ra_q;
  logic [IDX_W-1:0]  rb_q;
  logic [SIZE_W-1:0] era_q;
  logic [SIZE_W-1:0] set_size_q;

  logic [IDX_W-1:0]  idx_a;
  logic [IDX_W-1:0]  idx_b;
  logic [IDX_W-1:0]  walk_start;
  logic [IDX_W-1:0]  root_sel;
  logic [IDX_W-1:0]  parent_eff;
  logic [SIZE_W-1:0] extra_eff;
  logic [SIZE_W-1:0] sum_ext;
  logic [SIZE_W-1:0] size_res;
  logic              find_done;
  logic              cmp_done;
  logic              clr_last;
  logic              linked;

  assign idx_a      = IDX_W'(red_a_q);
  assign idx_b      = IDX_W'(red_b_q);
  assign walk_start = cmd_i.sel ? idx_b : idx_a;
  assign root_sel   = cmd_i.sel ? rb_q : ra_q;

  // An entry whose tag is from an older group reads as its reset value.
  assign parent_eff = (p_rdata_q[P_W-1 -: EPOCH_W] == epoch_q) ? p_rdata_q[IDX_W-1:0]
                                                               : p_raddr_q;
  assign extra_eff  = (x_rdata_q[X_W-1 -: EPOCH_W] == epoch_q) ? x_rdata_q[SIZE_W-1:0]
                                                               : '0;

  assign find_done = (parent_eff == cur_q);
  assign cmp_done  = (cur_q == root_sel);
  assign clr_last  = (clr_cnt_q == LAST_IDX);
  assign linked    = (ra_q != rb_q);
  assign sum_ext   = extra_eff + era_q + SIZE_W'(1);
  assign size_res  = (linked ? sum_ext : extra_eff) + SIZE_W'(1);

  assign sts_o.clr_last  = clr_last;
  assign sts_o.red_last  = &red_cnt_q;
  assign sts_o.find_done = find_done;
  assign sts_o.cmp_done  = cmp_done;
  assign sts_o.wrap_req  = new_group_i && (&epoch_q);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign set_size_o  = set_size_q;

  // Four restoring compare-subtract steps of the index reduction per cycle.
  always_comb begin
    logic [3:0]        k;
    logic [2*IN_W-1:0] shifted;
    red_a_next = red_a_q;
    red_b_next = red_b_q;
    for (int s = 0; s < RED_STEPS; s++) begin
      k       = ~{red_cnt_q, 2'(s)};
      shifted = MOD_N << k;
      if ({{IN_W{1'b0}}, red_a_next} >= shifted) begin
        red_a_next = red_a_next - shifted[IN_W-1:0];
      end
      if ({{IN_W{1'b0}}, red_b_next} >= shifted) begin
        red_b_next = red_b_next - shifted[IN_W-1:0];
      end
    end
  end

  always_comb begin
    p_we        = 1'b0;
    p_waddr     = cur_q;
    p_wdata     = {epoch_q, root_sel};
    p_raddr     = cur_q;
    x_we        = 1'b0;
    x_waddr     = rb_q;
    x_wdata     = {epoch_q, sum_ext};
    x_raddr     = rb_q;
    cur_d       = cur_q;
    epoch_d     = epoch_q;
    clr_cnt_d   = clr_cnt_q;
    red_cnt_d   = red_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      OP_LOAD: begin
        red_cnt_d = '0;
        if (new_group_i) begin
          epoch_d = epoch_q + EPOCH_W'(1);
        end
      end
      OP_CLR: begin
        p_we      = 1'b1;
        p_waddr   = clr_cnt_q;
        p_wdata   = {{EPOCH_W{1'b0}}, clr_cnt_q};
        x_we      = 1'b1;
        x_waddr   = clr_cnt_q;
        x_wdata   = '0;
        clr_cnt_d = clr_last ? '0 : clr_cnt_q + IDX_W'(1);
      end
      OP_RED: begin
        red_cnt_d = red_cnt_q + 2'd1;
      end
      OP_FIND_START, OP_CMP_START: begin
        cur_d   = walk_start;
        p_raddr = walk_start;
      end
      OP_FIND: begin
        if (!find_done) begin
          cur_d   = parent_eff;
          p_raddr = parent_eff;
        end
      end
      OP_CMP: begin
        if (!cmp_done) begin
          p_we    = 1'b1;
          cur_d   = parent_eff;
          p_raddr = parent_eff;
        end
      end
      OP_EXT_RA: begin
        x_raddr = ra_q;
        p_we    = linked;
        p_waddr = ra_q;
        p_wdata = {epoch_q, rb_q};
      end
      OP_EXT_RB: begin
        x_raddr = rb_q;
      end
      OP_SUM: begin
        x_we        = linked;
        out_valid_d = 1'b1;
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    p_rdata_q <= p_mem[p_raddr];
    p_raddr_q <= p_raddr;
  end

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[x_waddr] <= x_wdata;
    end
    x_rdata_q <= x_mem[x_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= '0;
      clr_cnt_q   <= '0;
      red_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      epoch_q     <= epoch_d;
      clr_cnt_q   <= clr_cnt_d;
      red_cnt_q   <= red_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.op == OP_LOAD) begin
      red_a_q <= elem_a_i;
      red_b_q <= elem_b_i;
    end else if (cmd_i.op == OP_RED) begin
      red_a_q <= red_a_next;
      red_b_q <= red_b_next;
    end
    if (cmd_i.op == OP_FIND && find_done) begin
      if (cmd_i.sel) begin
        rb_q <= cur_q;
      end else begin
        ra_q <= cur_q;
      end
    end
    if (cmd_i.op == OP_EXT_RB) begin
      era_q <= extra_eff;
    end
    if (cmd_i.op == OP_SUM) begin
      set_size_q <= size_res;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import ufsz_pkg::*;

  localparam int unsigned ELEMS       = NUM_ELEMENTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned PHASE_ITEMS = 480;
  localparam int unsigned DRAIN_WAIT  = 200;

  typedef struct {
    logic [IN_W-1:0] elem_a;
    logic [IN_W-1:0] elem_b;
    logic            new_group;
  } join_req_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [IN_W-1:0]   elem_a_i    = '0;
  logic [IN_W-1:0]   elem_b_i    = '0;
  logic              new_group_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [SIZE_W-1:0] set_size_o;

  join_req_t         pending_joins[$];
  logic [SIZE_W-1:0] expected_sizes[$];
  logic [IN_W-1:0]   parent_tab[ELEMS];
  logic [SIZE_W-1:0] extra_tab[ELEMS];
  logic [IN_W-1:0]   group_base = '0;
  join_req_t         next_join;
  logic [SIZE_W-1:0] want_size;
  int unsigned       src_idle_pct = 23;
  int unsigned       dst_idle_pct = 52;
  int unsigned       sizes_seen   = 0;
  int unsigned       hold_left    = 0;
  logic              hold_done    = 1'b0;
  int unsigned       err_cnt      = 0;
  int unsigned       cycle_cnt    = 0;

  union_find_with_set_size_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .elem_a_i   (elem_a_i),
    .elem_b_i   (elem_b_i),
    .new_group_i(new_group_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .set_size_o (set_size_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void clear_sets();
    for (int unsigned i = 0; i < ELEMS; i++) begin
      parent_tab[i] = IN_W'(i);
      extra_tab[i]  = '0;
    end
  endfunction

  function automatic logic [IN_W-1:0] find_root(logic [IN_W-1:0] node);
    logic [IN_W-1:0] root;
    logic [IN_W-1:0] cur;
    logic [IN_W-1:0] nxt;
    int unsigned     steps;
    root  = node;
    steps = 0;
    while (parent_tab[root] != root && steps < ELEMS) begin
      root = parent_tab[root];
      steps++;
    end
    cur   = node;
    steps = 0;
    while (cur != root && steps < ELEMS) begin
      nxt             = parent_tab[cur];
      parent_tab[cur] = root;
      cur             = nxt;
      steps++;
    end
    return root;
  endfunction

  function automatic logic [SIZE_W-1:0] join_sets(logic [IN_W-1:0] a, logic [IN_W-1:0] b,
                                                  logic grp);
    logic [IN_W-1:0] root_a;
    logic [IN_W-1:0] root_b;
    if (grp) begin
      clear_sets();
    end
    root_a = find_root(a);
    root_b = find_root(b);
    if (root_a != root_b) begin
      parent_tab[root_a] = root_b;
      extra_tab[root_b]  = extra_tab[root_b] + extra_tab[root_a] + 1'b1;
    end
    return extra_tab[root_b] + 1'b1;
  endfunction

  function automatic join_req_t draw_join();
    join_req_t   r;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = 1 << (2 * $urandom_range(1, 4));
    if ($urandom_range(0, 19) == 0) begin
      group_base = IN_W'($urandom);
    end
    r.elem_a    = group_base + IN_W'($urandom_range(0, span - 1));
    r.elem_b    = group_base + IN_W'($urandom_range(0, span - 1));
    r.new_group = ($urandom_range(0, 39) == 0);
    if (pick < 10) begin
      r.elem_a = IN_W'($urandom);
      r.elem_b = IN_W'($urandom);
    end else if (pick < 20) begin
      r.elem_b = r.elem_a;
    end else if (pick < 25) begin
      r.elem_a = $urandom_range(0, 1) ? '1 : '0;
      r.elem_b = $urandom_range(0, 1) ? '1 : IN_W'($urandom);
    end
    return r;
  endfunction

  function automatic void push_join(int unsigned a, int unsigned b, bit grp);
    join_req_t r;
    r.elem_a    = IN_W'(a);
    r.elem_b    = IN_W'(b);
    r.new_group = grp;
    pending_joins.insert(pending_joins.size(), r);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_joins.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_join = pending_joins.pop_front();
        in_valid_i  <= 1'b1;
        elem_a_i    <= next_join.elem_a;
        elem_b_i    <= next_join.elem_b;
        new_group_i <= next_join.new_group;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && sizes_seen >= HOLD_AFTER) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_sizes.insert(expected_sizes.size(),
                              join_sets(elem_a_i, elem_b_i, new_group_i));
      end
      if (out_valid_o && out_ready_i) begin
        sizes_seen <= sizes_seen + 1;
        if (expected_sizes.size() == 0) begin
          $error("set_size: unexpected transaction, expected none, actual %0d", set_size_o);
          err_cnt++;
        end else begin
          want_size = expected_sizes.pop_front();
          if (set_size_o !== want_size) begin
            $error("set_size mismatch: expected %0d, actual %0d", want_size, set_size_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    clear_sets();
    push_join(0, 0, 0);
    push_join(65535, 65535, 0);
    push_join(0, 65535, 0);
    push_join(1, 2, 0);
    push_join(2, 3, 0);
    push_join(3, 4, 0);
    push_join(1, 10, 0);
    push_join(1, 4, 0);
    push_join(10, 10, 0);
    push_join(16'h5555, 16'hAAAA, 0);
    push_join(16'hAAAA, 16'h5555, 0);
    push_join(65535, 0, 0);
    push_join(16'h8000, 16'h7FFF, 0);
    push_join(16'h7FFF, 2, 0);
    push_join(7, 7, 1);
    push_join(1, 4, 0);
    push_join(0, 65535, 0);
    push_join(65535, 16'h8000, 1);
    push_join(16'h8000, 0, 0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      src_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 52 : 0;
      dst_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 23 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pending_joins.insert(pending_joins.size(), draw_join());
      end
      while (pending_joins.size() != 0) @(negedge clk_i);
    end
    while (in_valid_i || expected_sizes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ufsz_pkg.sv
src/ufsz_ctrl.sv
src/ufsz_dp.sv
src/union_find_with_set_size_core.sv
verif/tb.sv
